// ----- src/mcbf_pkg.sv -----
// Shared types and constants for the multi-channel byte FIFO.
package mcbf_pkg;

  // Operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_OPEN = 3'd1;
  localparam logic [2:0] ST_NO_FREE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned GRNT_W = 3;
  localparam int unsigned CNT_W  = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EVAL,
    CS_RDWAIT
  } ctl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;    // capture the accepted request
    logic rd_issue; // start the byte store read
    logic commit;   // apply state updates and load the result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_read; // request is a read that will succeed
  } dp_sts_t;

endpackage

// ----- src/multi_channel_byte_fifo.sv -----
// Top level of the multi-channel byte FIFO: controller, datapath and checks.
// A table of CHANNELS byte queues, DEPTH bytes each, driven by one request
// per handshake (open, close, write byte, read byte); every request returns
// exactly one result with a status, the granted channel on open and the
// byte removed on read. Requests are handled one at a time: a request is
// captured into the request registers, then evaluated and committed into
// the result register; a successful read first passes through the
// registered read port of the byte store and is committed after that. in_ready
// is high whenever no
// request is in flight and reset is released, even while the previous result
// still waits in the output register; a request finishes only once that
// register is free, so a stalled out_ready holds it back from commit. Channel
// table state resets at once; the byte store needs no clearing, since a
// queue never reads a slot it has not written.
module multi_channel_byte_fifo #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned DEPTH    = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [mcbf_pkg::ID_W-1:0]   in_channel_id,
  input  logic [mcbf_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mcbf_pkg::STAT_W-1:0] out_status,
  output logic [mcbf_pkg::GRNT_W-1:0] out_granted_channel,
  output logic [mcbf_pkg::BYTE_W-1:0] out_read_byte
);
  import mcbf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: capture, evaluate, optional store read, commit
  mcbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Channel table, byte store and result register
  mcbf_datapath #(
    .CHANNELS (CHANNELS),
    .DEPTH    (DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_op               (in_op),
    .in_channel_id       (in_channel_id),
    .in_data_byte        (in_data_byte),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_status          (out_status),
    .out_granted_channel (out_granted_channel),
    .out_read_byte       (out_read_byte)
  );

  // A result is loaded only into a free output slot
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // One request in flight: after an accept, no new accept next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A store read and a commit never happen in the same cycle
  a_read_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> !cmd.commit)
    else $error("commit issued together with store read");

  // Every commit presents a result on the next cycle
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed request produced no result");

  // Status codes stay in the defined range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_EMPTY))
    else $error("undefined status code");

endmodule

// ----- src/mcbf_ctrl.sv -----
// Controller state machine: sequences one request at a time and owns out_valid.
module mcbf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mcbf_pkg::dp_sts_t sts,
  output mcbf_pkg::dp_cmd_t cmd
);
  import mcbf_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EVAL;
      end
      CS_EVAL: begin
        if (sts.need_read) state_nxt = CS_RDWAIT;
        else if (slot_free) state_nxt = CS_IDLE;
      end
      CS_RDWAIT: begin
        if (slot_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // No request is taken while reset is held
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready  = rst_n;
        cmd.latch = in_valid && rst_n;
      end
      CS_EVAL: begin
        if (sts.need_read) cmd.rd_issue = 1'b1;
        else cmd.commit = slot_free;
      end
      CS_RDWAIT: begin
        cmd.commit = slot_free;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/mcbf_datapath.sv -----
// Datapath: channel table, byte store, request evaluation and result register.
module mcbf_datapath #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned DEPTH    = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_op,
  input  logic [mcbf_pkg::ID_W-1:0]      in_channel_id,
  input  logic [mcbf_pkg::BYTE_W-1:0]    in_data_byte,
  input  mcbf_pkg::dp_cmd_t              cmd,
  output mcbf_pkg::dp_sts_t              sts,
  output logic [mcbf_pkg::STAT_W-1:0]    out_status,
  output logic [mcbf_pkg::GRNT_W-1:0]    out_granted_channel,
  output logic [mcbf_pkg::BYTE_W-1:0]    out_read_byte
);
  import mcbf_pkg::*;

  localparam int unsigned IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW    = $clog2(2 * DEPTH);
  localparam int unsigned SW    = $clog2(DEPTH);
  localparam int unsigned AW    = $clog2(CHANNELS * DEPTH) > 0 ? $clog2(CHANNELS * DEPTH) : 1;
  localparam int unsigned GW    = (IW > GRNT_W) ? IW : GRNT_W;
  localparam int unsigned WORDS = CHANNELS * DEPTH;
  localparam logic [PW-1:0] POS_LAST = PW'(2 * DEPTH - 1);

  // Latched request
  logic [1:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [BYTE_W-1:0] data_r;

  // Channel table
  logic [CHANNELS-1:0] in_use_r;
  logic [CNT_W-1:0]    count_r [CHANNELS];
  logic [PW-1:0]       rpos_r  [CHANNELS];
  logic [PW-1:0]       wpos_r  [CHANNELS];

  // Byte store
  logic [BYTE_W-1:0]   store [WORDS];
  logic [BYTE_W-1:0]   mem_q_r;

  logic [STAT_W-1:0]   status_r;
  logic [GRNT_W-1:0]   granted_r;
  logic [BYTE_W-1:0]   rbyte_r;

  logic              id_valid;
  logic [IW-1:0]     idx;
  logic              cur_in_use;
  logic [CNT_W-1:0]  cur_count;
  logic [PW-1:0]     cur_rpos, cur_wpos;
  logic [PW:0]       fill;
  logic              is_full, is_empty;
  logic              found;
  logic [IW-1:0]     free_idx;
  logic [PW-1:0]     rslot_p, wslot_p;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [STAT_W-1:0] status_c;
  logic [IW-1:0]     grant_idx;
  logic [GW-1:0]     grant_wide;
  logic [CNT_W-1:0]  close_cnt;
  logic              ok;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      id_r   <= in_channel_id;
      data_r <= in_data_byte;
    end
  end

  assign id_valid   = (id_r < ID_W'(CHANNELS));
  assign idx        = id_r[IW-1:0];
  assign cur_in_use = id_valid && in_use_r[idx];
  assign cur_count  = count_r[idx];
  assign cur_rpos   = rpos_r[idx];
  assign cur_wpos   = wpos_r[idx];

  assign fill = (cur_wpos >= cur_rpos)
              ? ((PW+1)'(cur_wpos) - (PW+1)'(cur_rpos))
              : ((PW+1)'(cur_wpos) + (PW+1)'(2 * DEPTH) - (PW+1)'(cur_rpos));
  assign is_full  = (fill >= (PW+1)'(DEPTH));
  assign is_empty = (cur_wpos == cur_rpos);

  // Lowest free channel
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        found    = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    if (!id_valid) begin
      status_c = ST_NOT_OPEN;
    end else if (op_r == OP_OPEN) begin
      status_c = (cur_in_use || found) ? ST_OK : ST_NO_FREE;
    end else if (!cur_in_use) begin
      status_c = ST_NOT_OPEN;
    end else begin
      case (op_r)
        OP_WRITE: status_c = is_full  ? ST_FULL  : ST_OK;
        OP_READ:  status_c = is_empty ? ST_EMPTY : ST_OK;
        default:  status_c = ST_OK;
      endcase
    end
  end

  assign ok            = (status_c == ST_OK);
  assign sts.need_read = ok && (op_r == OP_READ);

  assign grant_idx  = cur_in_use ? idx : free_idx;
  assign grant_wide = GW'(grant_idx);

  assign rslot_p = (cur_rpos >= PW'(DEPTH)) ? cur_rpos - PW'(DEPTH) : cur_rpos;
  assign wslot_p = (cur_wpos >= PW'(DEPTH)) ? cur_wpos - PW'(DEPTH) : cur_wpos;
  assign rd_addr = AW'(idx) * AW'(DEPTH) + AW'(rslot_p[SW-1:0]);
  assign wr_addr = AW'(idx) * AW'(DEPTH) + AW'(wslot_p[SW-1:0]);

  assign close_cnt = (cur_count != '0) ? cur_count - CNT_W'(1) : '0;

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && ok && op_r == OP_WRITE) store[wr_addr] <= data_r;
    if (cmd.rd_issue) mem_q_r <= store[rd_addr];
  end

  // Channel table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i] <= '0;
        rpos_r[i]  <= '0;
        wpos_r[i]  <= '0;
      end
    end else if (cmd.commit && ok) begin
      case (op_r)
        OP_OPEN: begin
          if (cur_in_use) begin
            if (cur_count != CNT_MAX) count_r[idx] <= cur_count + CNT_W'(1);
          end else begin
            in_use_r[free_idx] <= 1'b1;
            count_r[free_idx]  <= CNT_W'(1);
            rpos_r[free_idx]   <= '0;
            wpos_r[free_idx]   <= '0;
          end
        end
        OP_CLOSE: begin
          count_r[idx] <= close_cnt;
          if (close_cnt == '0) in_use_r[idx] <= 1'b0;
        end
        OP_WRITE: wpos_r[idx] <= (cur_wpos == POS_LAST) ? '0 : cur_wpos + PW'(1);
        default:  rpos_r[idx] <= (cur_rpos == POS_LAST) ? '0 : cur_rpos + PW'(1);
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_c;
      granted_r <= (ok && op_r == OP_OPEN) ? grant_wide[GRNT_W-1:0] : '0;
      rbyte_r   <= (ok && op_r == OP_READ) ? mem_q_r : '0;
    end
  end

  assign out_status          = status_r;
  assign out_granted_channel = granted_r;
  assign out_read_byte       = rbyte_r;

endmodule
